[hw/rtl/dual_timer_interrupt_peripheral_defines.svh]
// Assertion macros used by the checker file.
`ifndef DUAL_TIMER_INTERRUPT_PERIPHERAL_DEFINES_SVH
`define DUAL_TIMER_INTERRUPT_PERIPHERAL_DEFINES_SVH

// Condition holds at every edge outside reset.
`define DTIP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DTIP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DTIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/dtip_pkg.sv]
package dtip_pkg;

   localparam int COUNT_W = 18;
   localparam int MASK_W  = 5;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   localparam logic [3:0] REG_PORT_A = 4'h0;
   localparam logic [3:0] REG_PORT_B = 4'h1;
   localparam logic [3:0] REG_DIR_A  = 4'h2;
   localparam logic [3:0] REG_DIR_B  = 4'h3;
   localparam logic [3:0] REG_TA_LO  = 4'h4;
   localparam logic [3:0] REG_TA_HI  = 4'h5;
   localparam logic [3:0] REG_TB_LO  = 4'h6;
   localparam logic [3:0] REG_TB_HI  = 4'h7;
   localparam logic [3:0] REG_ICR    = 4'hD;
   localparam logic [3:0] REG_CRA    = 4'hE;
   localparam logic [3:0] REG_CRB    = 4'hF;

   localparam int CTRL_RUN     = 0;
   localparam int CTRL_ONESHOT = 3;
   localparam int CTRL_LOAD    = 4;
   localparam int ICR_SET      = 7;
   localparam int ICR_IR       = 7;

   localparam logic [7:0] CTRL_STORE_MASK = 8'hEF;

   typedef logic signed [COUNT_W-1:0] count_type;

   typedef struct packed {
      count_type count;
      logic      stop;
      logic      underflow;
   } timer_result_type;

endpackage

[hw/rtl/dtip_timer.sv]
module dtip_timer (
   input  dtip_pkg::count_type        count_i,
   input  logic [7:0]                 control_i,
   input  logic [15:0]                latch_i,
   input  logic [7:0]                 ticks_i,
   output dtip_pkg::timer_result_type result_o
);

   logic signed [dtip_pkg::COUNT_W:0] diff;
   dtip_pkg::count_type                clamped;
   dtip_pkg::count_type                reloaded;
   logic                               saturate;

   assign diff     = {count_i[dtip_pkg::COUNT_W-1], count_i} - {11'd0, ticks_i};
   assign saturate = diff[dtip_pkg::COUNT_W] ^ diff[dtip_pkg::COUNT_W-1];
   // clamp at the most negative count
   assign clamped  = saturate ? {1'b1, {(dtip_pkg::COUNT_W-1){1'b0}}}
                              : diff[dtip_pkg::COUNT_W-1:0];
   assign reloaded = clamped + {2'b00, latch_i};

   always_comb begin
      result_o.count     = count_i;
      result_o.stop      = 1'b0;
      result_o.underflow = 1'b0;
      if (control_i[dtip_pkg::CTRL_RUN]) begin
         if (!clamped[dtip_pkg::COUNT_W-1] && (clamped != '0)) begin
            result_o.count = clamped;
         end else begin
            result_o.underflow = 1'b1;
            if (control_i[dtip_pkg::CTRL_ONESHOT]) begin
               result_o.count = clamped;
               result_o.stop  = 1'b1;
            end else begin
               result_o.count = reloaded;
            end
         end
      end
   end

endmodule

[hw/rtl/dual_timer_interrupt_peripheral.sv]
// Channel   Direction  Ports                      Content
// req       in         req_tvalid/tready/tdata/tuser  bus write, bus read or tick
// rsp       out        rsp_tvalid/tready/tdata    read byte, interrupt pulses, underflows
// csr       in         csr_p*                     interrupt routing register
//
// One item per cycle sustained while rsp does not stall; rsp_tvalid rises when
// the item moves from the input register to the result register (state update).
// Reset clears all timer, port and interrupt state and empties both registers.
// A stall on rsp holds the result register and then the input register; req
// keeps flowing while the result register is free or being drained.
module dual_timer_interrupt_peripheral (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // reg_addr[3:0], write_data[11:4], tick_count[19:12]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // read_data[7:0], irq_pulse[8], nmi_pulse[9],
                                   // underflow_flags[11:10]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                 nmi_sel_ff;
   logic                 s1_valid_ff;
   dtip_pkg::kind_type   s1_kind_ff;
   logic [3:0]           s1_addr_ff;
   logic [7:0]           s1_wdata_ff;
   logic [7:0]           s1_ticks_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   logic [7:0]  port_a_ff, port_a_in, port_b_ff, port_b_in;
   logic [7:0]  dir_a_ff, dir_a_in, dir_b_ff, dir_b_in;
   logic [15:0] latch_a_ff, latch_a_in, latch_b_ff, latch_b_in;
   dtip_pkg::count_type count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [7:0]  control_a_ff, control_a_in, control_b_ff, control_b_in;
   logic [dtip_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic [7:0]  flags_ff, flags_in;

   logic advance, take;
   logic [7:0] rd;
   logic [1:0] uf;
   logic raise;
   dtip_pkg::timer_result_type ta, tb;

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, nmi_sel_ff};

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign take       = s1_valid_ff && advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   dtip_timer u_timer_a (
      .count_i   (count_a_ff),
      .control_i (control_a_ff),
      .latch_i   (latch_a_ff),
      .ticks_i   (s1_ticks_ff),
      .result_o  (ta)
   );

   dtip_timer u_timer_b (
      .count_i   (count_b_ff),
      .control_i (control_b_ff),
      .latch_i   (latch_b_ff),
      .ticks_i   (s1_ticks_ff),
      .result_o  (tb)
   );

   always_comb begin
      port_a_in    = port_a_ff;
      port_b_in    = port_b_ff;
      dir_a_in     = dir_a_ff;
      dir_b_in     = dir_b_ff;
      latch_a_in   = latch_a_ff;
      latch_b_in   = latch_b_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      control_a_in = control_a_ff;
      control_b_in = control_b_ff;
      mask_in      = mask_ff;
      flags_in     = flags_ff;
      rd           = 8'd0;
      uf           = 2'd0;
      raise        = 1'b0;
      if (take) begin
         case (s1_kind_ff)
            dtip_pkg::KIND_WRITE: begin
               case (s1_addr_ff)
                  dtip_pkg::REG_PORT_A: port_a_in = s1_wdata_ff;
                  dtip_pkg::REG_PORT_B: port_b_in = s1_wdata_ff;
                  dtip_pkg::REG_DIR_A:  dir_a_in  = s1_wdata_ff;
                  dtip_pkg::REG_DIR_B:  dir_b_in  = s1_wdata_ff;
                  dtip_pkg::REG_TA_LO:  latch_a_in[7:0]  = s1_wdata_ff;
                  dtip_pkg::REG_TA_HI:  latch_a_in[15:8] = s1_wdata_ff;
                  dtip_pkg::REG_TB_LO:  latch_b_in[7:0]  = s1_wdata_ff;
                  dtip_pkg::REG_TB_HI:  latch_b_in[15:8] = s1_wdata_ff;
                  dtip_pkg::REG_ICR: begin
                     if (s1_wdata_ff[dtip_pkg::ICR_SET]) begin
                        mask_in = mask_ff | s1_wdata_ff[dtip_pkg::MASK_W-1:0];
                     end else begin
                        mask_in = mask_ff & ~s1_wdata_ff[dtip_pkg::MASK_W-1:0];
                     end
                  end
                  dtip_pkg::REG_CRA: begin
                     if (s1_wdata_ff[dtip_pkg::CTRL_LOAD]) begin
                        count_a_in = {2'b00, latch_a_ff};
                     end
                     control_a_in = s1_wdata_ff & dtip_pkg::CTRL_STORE_MASK;
                  end
                  dtip_pkg::REG_CRB: begin
                     if (s1_wdata_ff[dtip_pkg::CTRL_LOAD]) begin
                        count_b_in = {2'b00, latch_b_ff};
                     end
                     control_b_in = s1_wdata_ff & dtip_pkg::CTRL_STORE_MASK;
                  end
                  default: ;
               endcase
            end
            dtip_pkg::KIND_READ: begin
               case (s1_addr_ff)
                  dtip_pkg::REG_PORT_A: rd = port_a_ff;
                  dtip_pkg::REG_PORT_B: rd = port_b_ff;
                  dtip_pkg::REG_DIR_A:  rd = dir_a_ff;
                  dtip_pkg::REG_DIR_B:  rd = dir_b_ff;
                  dtip_pkg::REG_TA_LO:  rd = count_a_ff[7:0];
                  dtip_pkg::REG_TA_HI:  rd = count_a_ff[15:8];
                  dtip_pkg::REG_TB_LO:  rd = count_b_ff[7:0];
                  dtip_pkg::REG_TB_HI:  rd = count_b_ff[15:8];
                  dtip_pkg::REG_ICR: begin
                     rd       = flags_ff;
                     flags_in = 8'd0;
                  end
                  dtip_pkg::REG_CRA:    rd = control_a_ff;
                  dtip_pkg::REG_CRB:    rd = control_b_ff;
                  default:              rd = 8'd0;
               endcase
            end
            dtip_pkg::KIND_TICK: begin
               count_a_in = ta.count;
               count_b_in = tb.count;
               if (ta.stop) begin
                  control_a_in[dtip_pkg::CTRL_RUN] = 1'b0;
               end
               if (tb.stop) begin
                  control_b_in[dtip_pkg::CTRL_RUN] = 1'b0;
               end
               uf    = {tb.underflow, ta.underflow};
               raise = (ta.underflow && mask_ff[0]) || (tb.underflow && mask_ff[1]);
               flags_in = flags_ff | {raise, 5'd0, uf};
            end
            default: ;
         endcase
      end
      rsp_data_in = {4'd0, uf, raise && nmi_sel_ff, raise && !nmi_sel_ff, rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nmi_sel_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         port_a_ff    <= '0;
         port_b_ff    <= '0;
         dir_a_ff     <= '0;
         dir_b_ff     <= '0;
         latch_a_ff   <= '0;
         latch_b_ff   <= '0;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         control_a_ff <= '0;
         control_b_ff <= '0;
         mask_ff      <= '0;
         flags_ff     <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
            nmi_sel_ff <= csr_pwdata[0];
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         port_a_ff    <= port_a_in;
         port_b_ff    <= port_b_in;
         dir_a_ff     <= dir_a_in;
         dir_b_ff     <= dir_b_in;
         latch_a_ff   <= latch_a_in;
         latch_b_ff   <= latch_b_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         control_a_ff <= control_a_in;
         control_b_ff <= control_b_in;
         mask_ff      <= mask_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_kind_ff  <= dtip_pkg::kind_type'(req_tuser);
         s1_addr_ff  <= req_tdata[3:0];
         s1_wdata_ff <= req_tdata[11:4];
         s1_ticks_ff <= req_tdata[19:12];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[hw/rtl/dtip_checker.sv]
`include "dual_timer_interrupt_peripheral_defines.svh"

module dtip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic stall, both_lines, pulse, tick_rsp, rd_zero;

   assign stall      = rsp_tvalid && !rsp_tready;
   assign both_lines = rsp_tvalid && rsp_tdata[8] && rsp_tdata[9];
   assign pulse      = rsp_tvalid && (rsp_tdata[8] || rsp_tdata[9]);
   assign tick_rsp   = rsp_tvalid && (rsp_tdata[11:10] != 2'd0);
   assign rd_zero    = (rsp_tdata[7:0] == 8'd0);

   `DTIP_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_tvalid && $stable(rsp_tdata), "rsp not held")

   `DTIP_ASSERT_ALWAYS(a_one_line, clock, reset, !both_lines, "irq and nmi pulsed together")

   `DTIP_ASSERT_IMPL(a_pulse_cause, clock, reset, pulse, tick_rsp, "pulse without underflow")

   `DTIP_ASSERT_IMPL(a_tick_no_data, clock, reset, tick_rsp, rd_zero, "read data on a tick")

   `DTIP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready, "busy after reset")

endmodule

bind dual_timer_interrupt_peripheral dtip_checker u_dtip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
